FILE: src/rau_pkg.sv
package rau_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int FIELD_W   = 32;

	// operation codes
	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_MUL    = 3'd2;
	localparam logic [2:0] OP_INV    = 3'd3;
	localparam logic [2:0] OP_RED    = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN  = 2'd1;
	localparam logic [1:0] ST_NO_INVERT = 2'd2;

endpackage

FILE: src/rational_arithmetic_unit.sv
// Rational-number unit: one request gives one result. Create, invert and
// unused codes finish straight from dispatch; add and multiply run their
// products one at a time through a single WIDTH x WIDTH multiplier. Reduce
// with a nonzero numerator runs the Euclidean GCD on one shared restoring
// divider that resolves one quotient bit per cycle, then divides both
// magnitudes by the GCD on the same divider; a zero numerator gives 0/1.
// The unit takes no new request until its result beat is taken.
module rational_arithmetic_unit #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  req_type,
	input  logic signed [rau_pkg::FIELD_W-1:0] a_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] a_den,
	input  logic signed [rau_pkg::FIELD_W-1:0] b_num,
	input  logic signed [rau_pkg::FIELD_W-1:0] b_den,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [rau_pkg::FIELD_W-1:0] res_num,
	output logic signed [rau_pkg::FIELD_W-1:0] res_den,
	output logic [1:0]                  status
);

	localparam int FW = rau_pkg::FIELD_W;
	localparam int CW = $clog2(WIDTH + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_MUL0  = 4'd2;
	localparam logic [3:0] S_MUL1  = 4'd3;
	localparam logic [3:0] S_MUL2  = 4'd4;
	localparam logic [3:0] S_GCD   = 4'd5;
	localparam logic [3:0] S_DIVN  = 4'd6;
	localparam logic [3:0] S_DIVD  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [2:0] op_q;
	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic [WIDTH-1:0] rn_q, rd_q, acc_q;
	logic [1:0] st_q;
	logic [WIDTH-1:0] gx_q, gy_q;
	logic [WIDTH-1:0] div_n_q, div_d_q, quo_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic div_busy_q;

	// widen inputs: sign-extend / truncate to WIDTH
	function automatic logic [WIDTH-1:0] widen(input logic [FW-1:0] v);
		logic [WIDTH+FW-1:0] x;
		x = {{WIDTH{v[FW-1]}}, v};
		return x[WIDTH-1:0];
	endfunction

	function automatic logic [FW-1:0] narrow(input logic [WIDTH-1:0] v);
		logic [WIDTH+FW-1:0] x;
		x = {{FW{v[WIDTH-1]}}, v};
		return x[FW-1:0];
	endfunction

	function automatic logic [WIDTH-1:0] wabs(input logic [WIDTH-1:0] v);
		return v[WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// shared multiplier, operands chosen by state
	logic [WIDTH-1:0] mul_a, mul_b, mul_p;
	logic [2*WIDTH-1:0] mul_full;
	always_comb begin
		unique case (state_q)
			S_MUL0:  begin mul_a = ad_q; mul_b = bd_q; end
			S_MUL1:  begin mul_a = an_q; mul_b = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q; end
			default: begin mul_a = bn_q; mul_b = ad_q; end
		endcase
		mul_full = mul_a * mul_b;
		mul_p = mul_full[WIDTH-1:0];
	end

	// shared restoring divider step: one quotient bit per cycle
	logic [WIDTH:0] trial;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] quo_next;
	always_comb begin
		trial = {rem_q, div_n_q[WIDTH-1]} - {1'b0, div_d_q};
		rem_next = trial[WIDTH] ? {rem_q[WIDTH-2:0], div_n_q[WIDTH-1]} : trial[WIDTH-1:0];
		quo_next = {quo_q[WIDTH-2:0], ~trial[WIDTH]};
	end
	logic div_last;
	assign div_last = div_busy_q && (cnt_q == CW'(1));

	// divider load: next remainder step, or one of the two final divisions
	logic div_start;
	logic [WIDTH-1:0] div_n_init, div_d_init;
	always_comb begin
		div_start = 1'b0;
		div_n_init = gx_q;
		div_d_init = gy_q;
		if (state_q == S_GCD && !div_busy_q) begin
			div_start = 1'b1;
			if (gy_q == '0) begin
				div_n_init = wabs(an_q);
				div_d_init = gx_q;
			end
		end else if (state_q == S_DIVN && div_last) begin
			div_start = 1'b1;
			div_n_init = wabs(ad_q);
			div_d_init = gx_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign res_num = narrow(rn_q);
	assign res_den = narrow(rd_q);
	assign status = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_busy_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			// divider load or iteration
			if (div_start) begin
				div_n_q <= div_n_init;
				div_d_q <= div_d_init;
				rem_q <= '0;
				cnt_q <= CW'(WIDTH);
				div_busy_q <= 1'b1;
			end else if (div_busy_q) begin
				rem_q   <= rem_next;
				div_n_q <= {div_n_q[WIDTH-2:0], 1'b0};
				quo_q   <= quo_next;
				cnt_q   <= cnt_q - 1'b1;
				if (div_last) div_busy_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= req_type;
						an_q <= widen(a_num);
						ad_q <= widen(a_den);
						bn_q <= widen(b_num);
						bd_q <= widen(b_den);
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (op_q)
						rau_pkg::OP_CREATE: begin
							rn_q <= an_q;
							rd_q <= ad_q;
							st_q <= (ad_q == '0) ? rau_pkg::ST_ZERO_DEN : rau_pkg::ST_OK;
							state_q <= S_DONE;
						end
						rau_pkg::OP_ADD, rau_pkg::OP_MUL: begin
							st_q <= rau_pkg::ST_OK;
							state_q <= S_MUL0;
						end
						rau_pkg::OP_INV: begin
							// zero numerator echoes operand a
							rn_q <= (an_q == '0) ? an_q : ad_q;
							rd_q <= (an_q == '0) ? ad_q : an_q;
							st_q <= (an_q == '0) ? rau_pkg::ST_NO_INVERT : rau_pkg::ST_OK;
							state_q <= S_DONE;
						end
						rau_pkg::OP_RED: begin
							st_q <= rau_pkg::ST_OK;
							if (an_q == '0) begin
								rn_q <= '0;
								rd_q <= WIDTH'(1);
								state_q <= S_DONE;
							end else begin
								gx_q <= wabs(an_q);
								gy_q <= wabs(ad_q);
								state_q <= S_GCD;
							end
						end
						default: begin
							rn_q <= an_q;
							rd_q <= ad_q;
							st_q <= rau_pkg::ST_OK;
							state_q <= S_DONE;
						end
					endcase
				end
				// products through the one multiplier
				S_MUL0: begin
					rd_q <= mul_p;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					if (op_q == rau_pkg::OP_MUL) begin
						rn_q <= mul_p;
						state_q <= S_DONE;
					end else begin
						acc_q <= mul_p;
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					rn_q <= acc_q + mul_p;
					state_q <= S_DONE;
				end
				// Euclid: x,y <- y, x mod y
				S_GCD: begin
					if (!div_busy_q) begin
						if (gy_q == '0) state_q <= S_DIVN;
					end else if (div_last) begin
						gx_q <= gy_q;
						gy_q <= rem_next;
					end
				end
				S_DIVN: begin
					if (div_last) begin
						rn_q <= an_q[WIDTH-1] ? ~quo_next + 1'b1 : quo_next;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_last) begin
						rd_q <= ad_q[WIDTH-1] ? ~quo_next + 1'b1 : quo_next;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the divider only runs while reducing
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> (state_q == S_GCD || state_q == S_DIVN || state_q == S_DIVD))
		else $error("divider busy outside reduce");
	// never divide by zero
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> div_d_q != '0)
		else $error("divider started with zero divisor");
	// error status only from create or invert
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != rau_pkg::ST_OK) |->
		(op_q == rau_pkg::OP_CREATE || op_q == rau_pkg::OP_INV))
		else $error("error status from wrong op");
	// a finished result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(rn_q) && $stable(rd_q)))
		else $error("result dropped while stalled");

endmodule

FILE: tb/rau_checker.sv
`timescale 1ns / 1ps

module rau_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] res_num,
	input  logic [31:0] res_den,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		logic [1:0]  st;
	} rau_result_t;

	rau_result_t expected_q[$];

	function automatic logic [31:0] mag32(logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic [31:0] euclid(logic [31:0] x, logic [31:0] y);
		logic [31:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// compute the rational result of one request
	function automatic rau_result_t compute_rational(logic [2:0] op, logic [31:0] an,
			logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
		rau_result_t r;
		logic [31:0] g, qn, qd;
		r.num = an;
		r.den = ad;
		r.st  = rau_pkg::ST_OK;
		unique case (op)
			rau_pkg::OP_CREATE: if (ad == 0) r.st = rau_pkg::ST_ZERO_DEN;
			rau_pkg::OP_ADD: begin
				r.num = an * bd + bn * ad;
				r.den = ad * bd;
			end
			rau_pkg::OP_MUL: begin
				r.num = an * bn;
				r.den = ad * bd;
			end
			rau_pkg::OP_INV: begin
				if (an == 0) r.st = rau_pkg::ST_NO_INVERT;
				else begin
					r.num = ad;
					r.den = an;
				end
			end
			rau_pkg::OP_RED: begin
				if (an == 0) begin
					r.num = 32'd0;
					r.den = 32'd1;
				end else begin
					g  = euclid(mag32(an), mag32(ad));
					qn = mag32(an) / g;
					qd = mag32(ad) / g;
					r.num = an[31] ? (32'd0 - qn) : qn;
					r.den = ad[31] ? (32'd0 - qd) : qd;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// queue requests and check result beats
	always @(posedge clk) begin
		rau_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_q.push_back(compute_rational(req_type, a_num, a_den, b_num, b_den));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result beat", $realtime);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (res_num !== want.num) report_mismatch("res_num", res_num, want.num);
					if (res_den !== want.den) report_mismatch("res_den", res_den, want.den);
					if (status !== want.st) report_mismatch("status", {30'd0, status},
						{30'd0, want.st});
				end
			end
			pending = expected_q.size();
		end
	end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = rau_pkg::OP_CREATE;
	logic [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] res_num, res_den;
	logic [1:0]  status;
	int          fail_count, pending;
	bit          stimulus_done = 1'b0;
	bit          hold_recv = 1'b0;
	bit          quiet = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rational_arithmetic_unit u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .a_num, .a_den, .b_num, .b_den,
		.out_valid, .out_stall, .res_num, .res_den, .status
	);

	rau_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .a_num, .a_den, .b_num, .b_den,
		.out_valid, .out_stall, .res_num, .res_den, .status, .fail_count, .pending
	);

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			4, 5: return $urandom_range(0, 40) - 20;
			6: return $urandom_range(1, 5000) * $urandom_range(1, 64);
			default: return $urandom();
		endcase
	endfunction

	// offer one beat, hold it until accepted
	task automatic send_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd, bit may_idle);
		if (may_idle) begin
			while ($urandom_range(0, 99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// receiver: random stall, forced hold-off on request
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_recv) begin
				out_stall <= 1'b1;
				for (hold = 0; hold < 400; hold++) @(posedge clk);
				hold_recv = 1'b0;
				out_stall <= 1'b0;
			end else
				out_stall <= (!quiet && $urandom_range(0, 99) < 30);
		end
	end

	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [31:0] edge_vals[5];
		int i, wait_cnt;
		edge_vals = '{32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_beat(rau_pkg::OP_CREATE, 32'd3, 32'd0, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_CREATE, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd2, 32'd3, 1'b0);
		send_beat(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff, 1'b0);
		send_beat(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_MUL, 32'd6, 32'd7, 32'hffff_fffe, 32'd5, 1'b0);
		send_beat(rau_pkg::OP_INV, 32'd0, 32'd9, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_INV, 32'd5, 32'd0, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_INV, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'd0, 32'd12, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'hffff_fff4, 32'd0, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'd12, 32'hffff_fff8, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'h8000_0000, 32'd6, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0, 1'b0);
		send_beat(rau_pkg::OP_RED, 32'd832040, 32'd1346269, 32'd0, 32'd0, 1'b0);
		send_beat(3'd5, 32'd1, 32'd2, 32'd3, 32'd4, 1'b0);
		send_beat(3'd6, 32'hffff_ffff, 32'd0, 32'd0, 32'd0, 1'b0);
		send_beat(3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		for (i = 0; i < 5; i++)
			send_beat(rau_pkg::OP_ADD, edge_vals[i], edge_vals[4 - i], edge_vals[i],
				edge_vals[i], 1'b0);

		// random requests with pressure phases
		for (i = 0; i < 1030; i++) begin
			quiet = (i >= 300 && i < 450);
			if (i == 200) hold_recv = 1'b1;
			if (i == 600) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_beat(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4)), pick_value(), pick_value(), pick_value(),
				pick_value(), !quiet);
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;

		// drain
		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (2000) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
